FILE: sv/apc_pkg.sv
// apc_pkg: widths, register indexes, microprogram step codes and control-word ROM
// for the all-pass cascade block
// no dependencies
`default_nettype none

package apc_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int POLE_W         = 16;
  localparam int VAL_W          = 20;
  localparam int PROD_W         = POLE_W + VAL_W;
  localparam int RND_W          = PROD_W - 15;
  localparam int SUM_W          = RND_W + 2;
  localparam int ELEM_W         = 4;
  localparam int CNT_W          = 5;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int DEF_MAX_STAGES = 16;

  localparam logic [CFG_IDX_W-1:0] REG_POLE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FORM_B = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STAGES = CFG_IDX_W'(3);

  localparam logic signed [POLE_W-1:0] POLE_RST   = 16'sd16384;
  localparam logic [CNT_W-1:0]         STAGES_RST = 5'd8;

  localparam logic signed [SUM_W-1:0] VAL_MAX = SUM_W'(524287);
  localparam logic signed [SUM_W-1:0] VAL_MIN = -SUM_W'(524288);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(16384);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_Y,
    ST_MUL_X,
    ST_SUM,
    ST_EMIT,
    ST_ZERO
  } step_t;

  // jump condition of a control word
  typedef enum logic [1:0] {
    C_ALWAYS,   // go to nxt
    C_INPUT,    // hold until input transfer; start item to alt, else nxt
    C_SECTION,  // second section pending to alt, else nxt
    C_OUTPUT    // hold until output slot free; last stage to alt, else nxt
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  mem_rd;
    logic  mul_y;
    logic  mul_x;
    logic  sum_wr;
    logic  emit;
    logic  emit_zero;
    cond_t cond;
    step_t nxt;
    step_t alt;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '{in_ready: 1'b0, mem_rd: 1'b0, mul_y: 1'b0, mul_x: 1'b0, sum_wr: 1'b0,
          emit: 1'b0, emit_zero: 1'b0, cond: C_ALWAYS, nxt: ST_IDLE, alt: ST_IDLE};
    case (step)
      ST_IDLE: begin
        c.in_ready = 1'b1; c.cond = C_INPUT; c.nxt = ST_READ; c.alt = ST_ZERO;
      end
      ST_READ: begin
        c.mem_rd = 1'b1; c.nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        c.mul_y = 1'b1; c.nxt = ST_MUL_X;
      end
      ST_MUL_X: begin
        c.mul_x = 1'b1; c.nxt = ST_SUM;
      end
      ST_SUM: begin
        c.sum_wr = 1'b1; c.cond = C_SECTION; c.nxt = ST_EMIT; c.alt = ST_READ;
      end
      ST_EMIT: begin
        c.emit = 1'b1; c.cond = C_OUTPUT; c.nxt = ST_READ; c.alt = ST_IDLE;
      end
      ST_ZERO: begin
        c.emit = 1'b1; c.emit_zero = 1'b1; c.cond = C_OUTPUT; c.nxt = ST_ZERO;
        c.alt = ST_IDLE;
      end
      default: begin
        c.nxt = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/allpass_cascade_delay_line.sv
// allpass_cascade_delay_line: cascade of first-order all-pass stages run by a
// microprogrammed sequencer over one shared multiplier and a delay memory
// depends on apc_pkg
//
// Usage: one input transfer (start_req, sample) yields n result transfers, one per
// active stage in stage order, n = stage_count clamped to 1..MAX_STAGES; last
// marks the final one. Registers are written on the cfg channel (index, data),
// always ready; write them only while the block is idle.
// Each item runs the microprogram: each section is a memory read, two passes
// through the single 16x20 multiplier and a sum/write-back, and each stage adds
// one emit step; double mode runs two sections per stage. A start item emits
// one zero per active stage. A new item is taken only after the last result
// of the previous one has been emitted.
// in_ready is high only while the sequencer sits in its idle step.
// Results go through an output register; a stalled receiver holds the
// sequencer in its emit or zero step, nothing is dropped.
// Reset restores the register defaults and marks every delay entry invalid,
// so all delays read as zero at once; a start item also marks every entry invalid.
`default_nettype none

module allpass_cascade_delay_line #(
  parameter int MAX_STAGES = apc_pkg::DEF_MAX_STAGES
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  start_req,
  input  wire logic signed [apc_pkg::SAMPLE_W-1:0]   sample,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [apc_pkg::ELEM_W-1:0]                 element,
  output logic signed [apc_pkg::VAL_W-1:0]           value,
  output logic                                       last,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [apc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [apc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import apc_pkg::*;

  localparam int DEPTH = 2 * MAX_STAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (MAX_STAGES > 1) ? AW - 1 : 1;
  localparam int MW    = 2 * VAL_W;

  // configuration registers
  logic signed [POLE_W-1:0] pole;
  logic                     form_b;
  logic                     double_section;
  logic [CNT_W-1:0]         stage_count;

  // sequencer
  step_t upc, upc_next;
  ctrl_t ctrl;

  // datapath
  logic signed [VAL_W-1:0]  x_cur;
  logic signed [VAL_W-1:0]  y;
  logic [SW-1:0]            stage;
  logic [SW-1:0]            last_stage;
  logic                     sec;
  logic [AW-1:0]            addr;
  logic [MW-1:0]            mem [DEPTH];
  logic [DEPTH-1:0]         vld;
  logic [MW-1:0]            rd_q;
  logic                     rd_vld;
  logic signed [VAL_W-1:0]  dly_x;
  logic signed [VAL_W-1:0]  dly_y;
  logic signed [VAL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  prod_y;
  logic signed [RND_W-1:0]  prod_x;
  logic signed [SUM_W-1:0]  sum;
  logic signed [VAL_W-1:0]  sat;
  logic [7:0]               n_ext;
  logic [7:0]               n_clamp;
  logic                     in_xfer;
  logic                     slot_free;
  logic                     is_last;
  logic                     go_emit;
  logic                     sec_pending;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole           <= POLE_RST;
      form_b         <= 1'b0;
      double_section <= 1'b0;
      stage_count    <= STAGES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POLE:   pole           <= signed'(cfg_data[POLE_W-1:0]);
        REG_FORM_B: form_b         <= cfg_data[0];
        REG_DOUBLE: double_section <= cfg_data[0];
        REG_STAGES: stage_count    <= cfg_data[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // control word from the microprogram ROM
  always_comb begin
    ctrl = ucode(upc);
  end

  assign in_ready    = ctrl.in_ready;
  assign in_xfer     = in_valid && ctrl.in_ready;
  assign slot_free   = !out_valid || out_ready;
  assign is_last     = (stage == last_stage);
  assign go_emit     = ctrl.emit && slot_free;
  assign sec_pending = double_section && !sec;

  always_comb begin
    upc_next = upc;
    case (ctrl.cond)
      C_ALWAYS:  upc_next = ctrl.nxt;
      C_INPUT: begin
        if (in_valid) upc_next = start_req ? ctrl.alt : ctrl.nxt;
      end
      C_SECTION: upc_next = sec_pending ? ctrl.alt : ctrl.nxt;
      C_OUTPUT: begin
        if (slot_free) upc_next = is_last ? ctrl.alt : ctrl.nxt;
      end
      default:   upc_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // active stage count, zero counts as one, above MAX_STAGES clamps to MAX_STAGES
  always_comb begin
    n_ext   = 8'(stage_count);
    n_clamp = n_ext;
    if (n_ext == 8'd0) n_clamp = 8'd1;
    if (n_ext > 8'(MAX_STAGES)) n_clamp = 8'(MAX_STAGES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= '0;
      sec        <= 1'b0;
      last_stage <= '0;
    end else if (in_xfer) begin
      stage      <= '0;
      sec        <= 1'b0;
      last_stage <= SW'(n_clamp - 8'd1);
    end else if (ctrl.sum_wr && sec_pending) begin
      sec <= 1'b1;
    end else if (go_emit) begin
      stage <= stage + SW'(1);
      sec   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_cur <= VAL_W'(sample);
    end else if (ctrl.sum_wr && sec_pending) begin
      x_cur <= sat;
    end else if (go_emit) begin
      x_cur <= y;
    end
  end

  assign addr = AW'({stage, sec});

  // delay memory: {previous input, previous output} per section
  always_ff @(posedge clk) begin
    if (ctrl.sum_wr) begin
      mem[addr] <= {x_cur, sat};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_rd) begin
      rd_q <= mem[addr];
    end
  end

  // entry valid bits; an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (in_xfer && start_req) begin
        vld <= '0;
      end else if (ctrl.sum_wr) begin
        vld[addr] <= 1'b1;
      end
      if (ctrl.mem_rd) rd_vld <= vld[addr];
    end
  end

  assign dly_x = rd_vld ? signed'(rd_q[MW-1:VAL_W]) : '0;
  assign dly_y = rd_vld ? signed'(rd_q[VAL_W-1:0]) : '0;

  // shared multiplier, Q1.15 pole times value, rounded half up back to the value scale
  assign mul_b     = ctrl.mul_y ? dly_y : x_cur;
  assign prod_full = PROD_W'(pole) * PROD_W'(mul_b);
  assign prod_rnd  = prod_full + RND_HALF;

  always_ff @(posedge clk) begin
    if (ctrl.mul_y) prod_y <= prod_rnd[PROD_W-1:15];
    if (ctrl.mul_x) prod_x <= prod_rnd[PROD_W-1:15];
  end

  always_comb begin
    if (form_b) begin
      sum = SUM_W'(prod_y) + SUM_W'(prod_x) - SUM_W'(dly_x);
    end else begin
      sum = SUM_W'(prod_y) - SUM_W'(prod_x) + SUM_W'(dly_x);
    end
    if (sum > VAL_MAX) begin
      sat = VAL_MAX[VAL_W-1:0];
    end else if (sum < VAL_MIN) begin
      sat = VAL_MIN[VAL_W-1:0];
    end else begin
      sat = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_wr) y <= sat;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go_emit) begin
      element <= ELEM_W'(stage);
      value   <= ctrl.emit_zero ? '0 : y;
      last    <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_req |=> vld == '0)
    else $error("start transfer did not clear delay entries");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit && slot_free && is_last |=> upc == ST_IDLE && out_valid && last)
    else $error("last stage emitted without returning to idle");

  a_stage_bound: assert property (@(posedge clk) disable iff (rst)
    upc != ST_IDLE |-> stage <= last_stage)
    else $error("stage index beyond active stage count");

  // second section flag stays up until the stage result is emitted
  a_sec_double: assert property (@(posedge clk) disable iff (rst)
    sec |-> double_section && (upc == ST_READ || upc == ST_MUL_Y ||
                               upc == ST_MUL_X || upc == ST_SUM ||
                               upc == ST_EMIT))
    else $error("second section outside double mode or section steps");
`endif

endmodule

`default_nettype wire

FILE: test/allpass_cascade_delay_line_test.sv
// allpass_cascade_delay_line_test: self-checking bench for the all-pass cascade,
// with its own fixed-point model of every stage, random stalls on both channels
// depends on apc_pkg and allpass_cascade_delay_line
`default_nettype none

module allpass_cascade_delay_line_test;
  import apc_pkg::*;

  localparam int NSTAGE     = DEF_MAX_STAGES;
  localparam int NSECT      = 2 * NSTAGE;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE     = 12;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(15);

  typedef struct {
    logic [ELEM_W-1:0]       elem;
    logic signed [VAL_W-1:0] val;
    logic                    last;
  } stage_res_t;

  logic clk = 1'b1;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_req = 1'b0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ELEM_W-1:0] element;
  logic signed [VAL_W-1:0] value;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model copy of registers and delay memory
  logic signed [POLE_W-1:0] m_pole;
  logic m_form_b;
  logic m_double;
  logic [CNT_W-1:0] m_stages;
  logic signed [VAL_W-1:0] x_hist [NSECT];
  logic signed [VAL_W-1:0] y_hist [NSECT];

  stage_res_t pending_stage_q [$];
  int err_cnt = 0;
  int idle_cnt = 0;
  int burst_left = 0;
  bit tx_no_gap = 1'b0;
  int hold_req_id = 0;

  allpass_cascade_delay_line u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_req (start_req),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .element   (element),
    .value     (value),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b0;
    #1 clk = 1'b1;
  end

  function automatic longint pole_mul(longint v);
    longint p;
    p = longint'(m_pole) * v + 64'sd16384;
    return p >>> 15;
  endfunction

  function automatic logic signed [VAL_W-1:0] allpass_section(int idx,
                                                              logic signed [VAL_W-1:0] x);
    longint acc;
    if (m_form_b) begin
      acc = pole_mul(y_hist[idx]) + pole_mul(x) - longint'(x_hist[idx]);
    end else begin
      acc = pole_mul(y_hist[idx]) - pole_mul(x) + longint'(x_hist[idx]);
    end
    if (acc > 64'sd524287) acc = 64'sd524287;
    if (acc < -64'sd524288) acc = -64'sd524288;
    x_hist[idx] = x;
    y_hist[idx] = acc[VAL_W-1:0];
    return acc[VAL_W-1:0];
  endfunction

  function automatic void clear_delays();
    for (int i = 0; i < NSECT; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
  endfunction

  function automatic void run_cascade(logic start, logic signed [SAMPLE_W-1:0] smp);
    int n;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    stage_res_t r;
    n = m_stages;
    if (n < 1) n = 1;
    if (n > NSTAGE) n = NSTAGE;
    x = smp;
    if (start) clear_delays();
    for (int s = 0; s < n; s++) begin
      y = '0;
      if (!start) begin
        y = allpass_section(2 * s, x);
        if (m_double) y = allpass_section(2 * s + 1, y);
        x = y;
      end
      r.elem = ELEM_W'(s);
      r.val  = y;
      r.last = (s == n - 1);
      pending_stage_q.push_back(r);
    end
  endfunction

  // model follows every accepted transfer
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) run_cascade(start_req, sample);
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLE:   m_pole = cfg_data;
        REG_FORM_B: m_form_b = cfg_data[0];
        REG_DOUBLE: m_double = cfg_data[0];
        REG_STAGES: m_stages = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    stage_res_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_stage_q.size() == 0) begin
        $error("unexpected result: element %0d value %0d last %0b", element, value, last);
        err_cnt++;
      end else begin
        w = pending_stage_q.pop_front();
        if (element !== w.elem) begin
          $error("element: expected %0d, got %0d", w.elem, element);
          err_cnt++;
        end
        if (value !== w.val) begin
          $error("value: expected %0d, got %0d", w.val, value);
          err_cnt++;
        end
        if (last !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, last);
          err_cnt++;
        end
      end
    end
  end

  // receiver: random ready pattern from one of four modes, long hold-off on request
  always @(negedge clk) begin
    int tick;
    int mode;
    int hold_cnt;
    int seen_id;
    logic [7:0] mask;
    if (tick % 64 == 0) begin
      mode = $urandom_range(0, 3);
      mask = 8'($urandom);
    end
    tick++;
    if (hold_req_id != seen_id) begin
      seen_id  = hold_req_id;
      hold_cnt = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= mask[tick % 8] | (mask == 8'h00);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
    end
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(logic start, logic signed [SAMPLE_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = tx_no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    start_req <= start;
    sample    <= smp;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // sender quiet, every result back, sequencer settled
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (pending_stage_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_pole();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_stages();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(31);
    case ($urandom_range(0, 9))
      0: return d | 16'd0;
      1: return d | 16'd16;
      2: return d | CFG_DATA_W'($urandom_range(17, 31));
      3: return d | 16'd1;
      default: return d | CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_item(1'b1, 16'sh1234);
    send_item(1'b0, 16'sh7fff);
    send_item(1'b0, 16'sh8000);
    send_item(1'b0, 16'sh0000);
    send_item(1'b0, 16'sh0001);
    send_item(1'b0, 16'shffff);
    wait_idle();
  endtask

  task automatic test_directed_extremes();
    // full pole, double sections, all stages: drive into saturation
    write_reg(REG_POLE, 16'h7fff);
    write_reg(REG_DOUBLE, 16'h0001);
    write_reg(REG_STAGES, 16'd16);
    send_item(1'b1, 16'sh0000);
    for (int i = 0; i < 4; i++) send_item(1'b0, i[0] ? 16'sh8000 : 16'sh7fff);
    wait_idle();
    // negative full pole in form b, stage count clamped up from zero
    write_reg(REG_POLE, 16'h8000);
    write_reg(REG_FORM_B, 16'h0001);
    write_reg(REG_DOUBLE, 16'h0000);
    write_reg(REG_STAGES, 16'd0);
    for (int i = 0; i < 4; i++) send_item(1'b0, i[1] ? 16'sh7fff : 16'sh8000);
    wait_idle();
    // count above the maximum clamps down; inactive stages keep their history
    write_reg(REG_STAGES, 16'hffff);
    send_item(1'b0, 16'sh4000);
    send_item(1'b0, 16'shc000);
    wait_idle();
    write_reg(REG_SPARE_LO, 16'hffff);
    write_reg(REG_SPARE_HI, 16'h5a5a);
    send_item(1'b1, 16'sh7fff);
    send_item(1'b0, 16'sh0001);
    wait_idle();
  endtask

  task automatic test_config_sweep(int phases, int items_per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(REG_POLE, rand_pole());
      write_reg(REG_FORM_B, CFG_DATA_W'($urandom));
      write_reg(REG_DOUBLE, CFG_DATA_W'($urandom));
      write_reg(REG_STAGES, rand_stages());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  CFG_DATA_W'($urandom));
      end
      tx_no_gap = ($urandom_range(0, 3) == 0);
      // mostly a start followed by a run of samples, some stray starts
      send_item(1'b1, rand_sample());
      for (int i = 0; i < items_per_phase; i++) begin
        send_item($urandom_range(0, 19) == 0, rand_sample());
      end
      tx_no_gap = 1'b0;
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_STAGES, 16'd4);
    write_reg(REG_DOUBLE, 16'h0000);
    hold_req_id++;
    tx_no_gap = 1'b1;
    for (int i = 0; i < 12; i++) send_item(1'b0, rand_sample());
    tx_no_gap = 1'b0;
    wait_idle();
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 5; i++) send_item(1'b0, rand_sample());
      wait_idle();
    end
  endtask

  initial begin
    m_pole   = POLE_RST;
    m_form_b = 1'b0;
    m_double = 1'b0;
    m_stages = STAGES_RST;
    clear_delays();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_defaults();
    test_directed_extremes();
    test_backpressure();
    test_config_sweep(11, 22);
    test_drain_pause();

    wait_idle();
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && pending_stage_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
